/* rtl/core/tss_pkg.sv */
// Shared types and codes for the task scheduler with counting semaphores.
// No dependencies.
package tss_pkg;

	localparam int TASKS_DEF      = 16;
	localparam int SEMAPHORES_DEF = 4;
	localparam int QDEPTH_DEF     = 16;

	localparam logic [2:0] CMD_SCHED = 3'd0;
	localparam logic [2:0] CMD_SLEEP = 3'd1;
	localparam logic [2:0] CMD_P     = 3'd2;
	localparam logic [2:0] CMD_V     = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;
	localparam logic [2:0] CMD_LTASK = 3'd5;
	localparam logic [2:0] CMD_LSEM  = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_READY = 2'd1;
	localparam logic [1:0] ST_Q_FULL   = 2'd2;
	localparam logic [1:0] ST_Q_EMPTY  = 2'd3;

	// ms / 10 as (ms * RECIP10) >> 19, exact over 16 bits
	localparam logic [15:0] RECIP10 = 16'd52429;

	localparam logic signed [6:0] SEM_MIN = -7'sd64;
	localparam logic signed [6:0] SEM_MAX = 7'sd63;

	typedef struct packed {
		logic capture;
		logic exec;
		logic pop;
		logic dec_sleep;
		logic clr_best;
		logic pick;
		logic refill;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic sched_next;
		logic pop_next;
		logic best_zero;
	} stat_t;

endpackage

/* rtl/core/tss_ctrl.sv */
// Controller state machine: sequences execute, sleep decrement, table scans,
// refill and queue pop. Depends on tss_pkg.
module tss_ctrl import tss_pkg::*; #(
	parameter int TASKS = TASKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  stat_t                      stat,
	output ctrl_t                      ctrl,
	output logic [$clog2(TASKS)-1:0]   pick_idx,
	output logic                       busy,
	output logic                       done
);
	localparam int TIW = $clog2(TASKS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_DEC    = 3'd2;
	localparam logic [2:0] S_PICK   = 3'd3;
	localparam logic [2:0] S_REFILL = 3'd4;
	localparam logic [2:0] S_QRD    = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0]     state_q, state_d;
	logic [TIW-1:0] scan_q;
	logic           pass_q;
	logic           done_q;
	logic           last;

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign pick_idx = scan_q;
	assign last     = (scan_q == TIW'(TASKS - 1));

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				ctrl.exec = 1'b1;
				if (stat.sched_next)
					state_d = S_DEC;
				else if (stat.pop_next)
					state_d = S_QRD;
				else
					state_d = S_IDLE;
			end
			S_DEC: begin
				ctrl.dec_sleep = 1'b1;
				ctrl.clr_best  = 1'b1;
				state_d        = S_PICK;
			end
			S_PICK: begin
				ctrl.pick = 1'b1;
				if (last) begin
					if (!pass_q && stat.best_zero)
						state_d = S_REFILL;
					else
						state_d = S_FIN;
				end
			end
			S_REFILL: begin
				ctrl.refill   = 1'b1;
				ctrl.clr_best = 1'b1;
				state_d       = S_PICK;
			end
			S_QRD: begin
				ctrl.pop = 1'b1;
				state_d  = S_IDLE;
			end
			S_FIN: begin
				ctrl.finish = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= busy && (state_d == S_IDLE);
			if (state_q == S_DEC)
				pass_q <= 1'b0;
			else if (state_q == S_REFILL)
				pass_q <= 1'b1;
			if (state_q == S_PICK)
				scan_q <= last ? '0 : scan_q + 1'b1;
			else
				scan_q <= '0;
		end
	end

endmodule

/* rtl/core/tss_dp.sv */
// Datapath: task table, semaphore values, wait queue memory and result words.
// Depends on tss_pkg; driven by tss_ctrl.
module tss_dp import tss_pkg::*; #(
	parameter int TASKS       = TASKS_DEF,
	parameter int SEMAPHORES  = SEMAPHORES_DEF,
	parameter int QUEUE_DEPTH = QDEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_t                     ctrl,
	input  logic [$clog2(TASKS)-1:0]  pick_idx,
	output stat_t                     stat,
	input  logic [2:0]                cmd,
	input  logic [3:0]                task_index,
	input  logic [15:0]               sleep_ms,
	input  logic [1:0]                sem_index,
	input  logic [7:0]                task_priority,
	input  logic [7:0]                task_ticks,
	input  logic signed [6:0]         sem_initial,
	output logic [3:0]                ready_task,
	output logic                      ready_valid,
	output logic [3:0]                woken_task,
	output logic                      woken_valid,
	output logic signed [6:0]         sem_value_out,
	output logic [1:0]                status
);
	localparam int TIW = $clog2(TASKS);
	localparam int SIW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int QAW = (SEMAPHORES * QUEUE_DEPTH > 2) ? $clog2(SEMAPHORES * QUEUE_DEPTH) : 1;

	// captured command word
	logic [2:0]        cmd_q;
	logic [3:0]        ti_q;
	logic [15:0]       ms_q;
	logic [1:0]        si_q;
	logic [7:0]        prio_q, tks_q;
	logic signed [6:0] init_q;

	logic [7:0]        ticks_q [TASKS];
	logic [7:0]        prio_tab_q [TASKS];
	logic [12:0]       sleep_q [TASKS];
	logic [TASKS-1:0]  wait_q;
	logic [TIW-1:0]    cur_q;
	logic              latch_q;
	logic signed [6:0] sem_q [SEMAPHORES];
	logic [PW-1:0]     head_q [SEMAPHORES];
	logic [CW-1:0]     cnt_q [SEMAPHORES];
	logic [7:0]        best_q;
	logic [TIW-1:0]    cand_q;
	logic [SIW-1:0]    popsem_q;

	logic [3:0]        woken_q;
	logic              wvalid_q;
	logic signed [6:0] semout_q;
	logic [1:0]        status_q;

	logic [TIW-1:0]    qmem [SEMAPHORES * QUEUE_DEPTH];
	logic [TIW-1:0]    rdata_q;
	logic              q_we, q_re;
	logic [QAW-1:0]    q_waddr, q_raddr;

	logic              ti_ok, si_ok;
	logic [TIW-1:0]    ti_l;
	logic [SIW-1:0]    si_l;
	logic signed [6:0] sem_cur;
	logic signed [7:0] dec_w, inc_w;
	logic signed [6:0] p_val, v_val;
	logic [CW-1:0]     cnt_cur;
	logic [PW-1:0]     head_cur, tail_pos, head_nxt;
	logic [CW:0]       tail_sum;
	logic              q_full;
	logic [31:0]       prod;
	logic              elig, upd;

	assign ti_ok   = ({1'b0, ti_q} < 5'(TASKS));
	assign si_ok   = ({1'b0, si_q} < 3'(SEMAPHORES));
	assign ti_l    = ti_q[TIW-1:0];
	assign si_l    = SIW'(si_q);
	assign sem_cur = sem_q[si_l];
	assign cnt_cur = cnt_q[si_l];
	assign head_cur = head_q[si_l];
	assign dec_w   = 8'(sem_cur) - 8'sd1;
	assign inc_w   = 8'(sem_cur) + 8'sd1;
	assign p_val   = (dec_w < 8'(SEM_MIN)) ? SEM_MIN : dec_w[6:0];
	assign v_val   = (inc_w > 8'(SEM_MAX)) ? SEM_MAX : inc_w[6:0];
	assign q_full  = (cnt_cur >= CW'(QUEUE_DEPTH));
	assign tail_sum = (CW+1)'(head_cur) + (CW+1)'(cnt_cur);
	assign tail_pos = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
	assign head_nxt = (head_q[popsem_q] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q[popsem_q] + 1'b1;
	assign prod    = ms_q * RECIP10;

	assign elig = (sleep_q[pick_idx] == '0) && !wait_q[pick_idx];
	assign upd  = elig && (ticks_q[pick_idx] > best_q);

	always_comb begin
		stat            = '0;
		stat.best_zero  = (best_q == '0) && !upd;
		q_we            = 1'b0;
		q_re            = 1'b0;
		q_waddr         = QAW'(si_l) * QAW'(QUEUE_DEPTH) + QAW'(tail_pos);
		q_raddr         = QAW'(si_l) * QAW'(QUEUE_DEPTH) + QAW'(head_cur);
		if (ctrl.exec) begin
			case (cmd_q)
				CMD_SCHED, CMD_SLEEP: stat.sched_next = 1'b1;
				CMD_P: begin
					if (si_ok && (p_val < 0) && !q_full) begin
						stat.sched_next = 1'b1;
						q_we            = 1'b1;
					end
				end
				CMD_V: begin
					if (si_ok && (v_val <= 0) && (cnt_cur != '0)) begin
						stat.pop_next = 1'b1;
						q_re          = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_we)
			qmem[q_waddr] <= cur_q;
		if (q_re)
			rdata_q <= qmem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASKS; i++) begin
				ticks_q[i]    <= '0;
				prio_tab_q[i] <= '0;
				sleep_q[i]    <= '0;
			end
			for (int s = 0; s < SEMAPHORES; s++) begin
				sem_q[s]  <= '0;
				head_q[s] <= '0;
				cnt_q[s]  <= '0;
			end
			wait_q   <= '0;
			cur_q    <= '0;
			latch_q  <= 1'b0;
			best_q   <= '0;
			cand_q   <= '0;
			popsem_q <= '0;
			woken_q  <= '0;
			wvalid_q <= 1'b0;
			semout_q <= '0;
			status_q <= ST_OK;
		end else begin
			if (ctrl.exec) begin
				woken_q  <= '0;
				wvalid_q <= 1'b0;
				semout_q <= '0;
				status_q <= ST_OK;
				popsem_q <= si_l;
				case (cmd_q)
					CMD_SLEEP: sleep_q[cur_q] <= prod[31:19];
					CMD_P: begin
						if (si_ok) begin
							if ((p_val < 0) && q_full) begin
								status_q <= ST_Q_FULL;
								semout_q <= sem_cur;
							end else begin
								sem_q[si_l] <= p_val;
								semout_q    <= p_val;
								if (p_val < 0) begin
									wait_q[cur_q] <= 1'b1;
									cnt_q[si_l]   <= cnt_cur + 1'b1;
								end
							end
						end
					end
					CMD_V: begin
						if (si_ok) begin
							sem_q[si_l] <= v_val;
							semout_q    <= v_val;
							if ((v_val <= 0) && (cnt_cur == '0))
								status_q <= ST_Q_EMPTY;
						end
					end
					CMD_TICK: begin
						if (ticks_q[cur_q] != '0)
							ticks_q[cur_q] <= ticks_q[cur_q] - 1'b1;
					end
					CMD_LTASK: begin
						if (ti_ok) begin
							ticks_q[ti_l]    <= tks_q;
							prio_tab_q[ti_l] <= prio_q;
							sleep_q[ti_l]    <= '0;
							wait_q[ti_l]     <= 1'b0;
						end
					end
					CMD_LSEM: begin
						if (si_ok) begin
							sem_q[si_l] <= init_q;
							cnt_q[si_l] <= '0;
							semout_q    <= init_q;
						end
					end
					default: ;
				endcase
			end
			if (ctrl.pop) begin
				wait_q[rdata_q]  <= 1'b0;
				woken_q          <= 4'(rdata_q);
				wvalid_q         <= 1'b1;
				head_q[popsem_q] <= head_nxt;
				cnt_q[popsem_q]  <= cnt_q[popsem_q] - 1'b1;
			end
			if (ctrl.dec_sleep) begin
				for (int i = 0; i < TASKS; i++)
					if (sleep_q[i] != '0)
						sleep_q[i] <= sleep_q[i] - 1'b1;
			end
			if (ctrl.refill) begin
				for (int i = 0; i < TASKS; i++)
					if ((sleep_q[i] == '0) && !wait_q[i])
						ticks_q[i] <= prio_tab_q[i];
			end
			if (ctrl.clr_best)
				best_q <= '0;
			else if (ctrl.pick && upd) begin
				best_q <= ticks_q[pick_idx];
				cand_q <= pick_idx;
			end
			if (ctrl.finish) begin
				if (best_q != '0) begin
					cur_q    <= cand_q;
					latch_q  <= 1'b1;
					status_q <= ST_OK;
				end else begin
					latch_q  <= 1'b0;
					status_q <= ST_NO_READY;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= cmd;
			ti_q   <= task_index;
			ms_q   <= sleep_ms;
			si_q   <= sem_index;
			prio_q <= task_priority;
			tks_q  <= task_ticks;
			init_q <= sem_initial;
		end
	end

	assign ready_task    = 4'(cur_q);
	assign ready_valid   = latch_q;
	assign woken_task    = woken_q;
	assign woken_valid   = wvalid_q;
	assign sem_value_out = semout_q;
	assign status        = status_q;

endmodule

/* rtl/core/task_scheduler_with_semaphores.sv */
// Top level of the task scheduler with counting semaphores.
// Depends on tss_pkg, tss_ctrl and tss_dp.
//
// channel  dir  handshake            word
// command  in   start & !busy        cmd, task_index, sleep_ms, sem_index,
//                                    task_priority, task_ticks, sem_initial
// result   out  done (one cycle)     ready_task, ready_valid, woken_task,
//                                    woken_valid, sem_value_out, status
//
// One command at a time. Load, tick and non-blocking P/V: execute, then done.
// V that wakes a waiter adds a queue memory read. Schedule, sleep and a
// blocking P add a sleep decrement and a serial walk of the task table (one
// entry a cycle), and a second walk when a refill is needed.
// Reset clears all tables; the queue memory needs no clearing.
// Results cannot be stalled: the word is valid only while done is high.
module task_scheduler_with_semaphores import tss_pkg::*; #(
	parameter int TASKS       = TASKS_DEF,
	parameter int SEMAPHORES  = SEMAPHORES_DEF,
	parameter int QUEUE_DEPTH = QDEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        cmd,
	input  logic [3:0]        task_index,
	input  logic [15:0]       sleep_ms,
	input  logic [1:0]        sem_index,
	input  logic [7:0]        task_priority,
	input  logic [7:0]        task_ticks,
	input  logic signed [6:0] sem_initial,
	output logic              done,
	output logic [3:0]        ready_task,
	output logic              ready_valid,
	output logic [3:0]        woken_task,
	output logic              woken_valid,
	output logic signed [6:0] sem_value_out,
	output logic [1:0]        status
);
	ctrl_t                    ctrl;
	stat_t                    stat;
	logic [$clog2(TASKS)-1:0] pick_idx;

	tss_ctrl #(.TASKS(TASKS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.stat     (stat),
		.ctrl     (ctrl),
		.pick_idx (pick_idx),
		.busy     (busy),
		.done     (done)
	);

	tss_dp #(
		.TASKS       (TASKS),
		.SEMAPHORES  (SEMAPHORES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.pick_idx      (pick_idx),
		.stat          (stat),
		.cmd           (cmd),
		.task_index    (task_index),
		.sleep_ms      (sleep_ms),
		.sem_index     (sem_index),
		.task_priority (task_priority),
		.task_ticks    (task_ticks),
		.sem_initial   (sem_initial),
		.ready_task    (ready_task),
		.ready_valid   (ready_valid),
		.woken_task    (woken_task),
		.woken_valid   (woken_valid),
		.sem_value_out (sem_value_out),
		.status        (status)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("accepted word not taken up");

	a_woken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && woken_valid |-> status == ST_OK) else $error("wake with bad status");

	a_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NO_READY |-> !ready_valid) else $error("no_ready but valid");

endmodule
